/* src/rtc_pkg.sv */
package rtc_pkg;

  // Roll points of the counters.
  localparam int unsigned SecPerMin   = 60;
  localparam int unsigned MinPerHour  = 60;
  localparam int unsigned HourPerDay  = 24;
  localparam int unsigned MonthRoll   = 13;
  localparam int unsigned LeapFebRoll = 30;

  // Values of the counters after reset.
  localparam logic [5:0]  ResetSecond = 6'd0;
  localparam logic [5:0]  ResetMinute = 6'd0;
  localparam logic [4:0]  ResetHour   = 5'd0;
  localparam logic [4:0]  ResetDay    = 5'd1;
  localparam logic [3:0]  ResetMonth  = 4'd1;
  localparam logic [15:0] ResetYear   = 16'd2023;

  localparam logic [4:0] FirstDay   = 5'd1;
  localparam logic [3:0] FirstMonth = 4'd1;
  localparam logic [3:0] MonthFeb   = 4'd2;

  typedef enum logic {
    OpTick = 1'b0,
    OpLoad = 1'b1
  } rtc_op_e;

  typedef struct packed {
    rtc_op_e     op;
    logic [5:0]  set_second;
    logic [5:0]  set_minute;
    logic [4:0]  set_hour;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [15:0] set_year;
  } rtc_in_t;

  typedef struct packed {
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    logic [5:0]  elapsed_mask;
  } rtc_out_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } rtc_time_t;

  // Days in a month outside leap February; codes that name no month count 31.
  function automatic logic [4:0] days_in(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:                    len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* src/calendar_clock_tick.sv */
// A transaction accepted at the input passes through the input register, then
// the result register.
// Throughput: one transaction per cycle while results are taken, as the time
// registers are updated as each transaction moves on; the next one reads them.
// Reset: asynchronous, active low; clears both valid flags and sets the time to
// 00:00:00 on January 1st, 2023.
module calendar_clock_tick import rtc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rtc_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rtc_out_t out_o
);

  // Input register. It holds one transaction until the result register has
  // room for its result.
  logic      in_valid_q;
  rtc_in_t   in_q;

  // Stored time. It is updated in the same cycle as the result register, so
  // a following transaction always sees the time left by the one before.
  rtc_time_t time_q, time_d;

  // Result register.
  logic      out_valid_q;
  rtc_out_t  out_q;

  logic       adv;
  logic [5:0] mask;

  // The item in the input register moves on when the result register is empty
  // or its result is being taken in this cycle.
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  // The input register takes a new transaction when it is empty or draining,
  // so a full pipe keeps accepting while results are taken.
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // Next time and elapsed mask from the stored time and the pending item.
  rtc_step u_step (
    .time_i (time_q),
    .item_i (in_q),
    .time_o (time_d),
    .mask_o (mask)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q.second <= ResetSecond;
      time_q.minute <= ResetMinute;
      time_q.hour   <= ResetHour;
      time_q.day    <= ResetDay;
      time_q.month  <= ResetMonth;
      time_q.year   <= ResetYear;
    end else if (adv) begin
      time_q <= time_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The result carries the time after the item, the same value written into
  // the time registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.cur_second   <= time_d.second;
      out_q.cur_minute   <= time_d.minute;
      out_q.cur_hour     <= time_d.hour;
      out_q.cur_day      <= time_d.day;
      out_q.cur_month    <= time_d.month;
      out_q.cur_year     <= time_d.year;
      out_q.elapsed_mask <= mask;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A load transaction reports no elapsed units.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (in_q.op == OpLoad) |=> out_q.elapsed_mask == '0)
    else $error("load result has a nonzero elapsed mask");

  // A tick always marks seconds, and carries form a run from bit zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (in_q.op == OpTick) |=> out_q.elapsed_mask[0] &&
      ((out_q.elapsed_mask & (out_q.elapsed_mask + 6'd1)) == '0))
    else $error("tick result has a malformed elapsed mask");

  // While a result waits, the stored time must not move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(time_q))
    else $error("time changed while a result was stalled");

  // A waiting result always shows the stored time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.cur_second == time_q.second) &&
      (out_q.cur_minute == time_q.minute) && (out_q.cur_hour == time_q.hour) &&
      (out_q.cur_day == time_q.day) && (out_q.cur_month == time_q.month) &&
      (out_q.cur_year == time_q.year))
    else $error("result time differs from stored time");

endmodule

/* src/rtc_step.sv */
module rtc_step import rtc_pkg::*; (
  input  rtc_time_t time_i,
  input  rtc_in_t   item_i,
  output rtc_time_t time_o,
  output logic [5:0] mask_o
);

  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;
  logic        sec_wrap, min_wrap, hour_wrap, day_roll, month_wrap, leap_feb;
  logic        c1, c2, c3, c4, c5;
  rtc_time_t   tick_time;

  always_comb begin
    sec_inc   = {1'b0, time_i.second} + 7'd1;
    min_inc   = {1'b0, time_i.minute} + 7'd1;
    hour_inc  = {1'b0, time_i.hour} + 6'd1;
    day_inc   = {1'b0, time_i.day} + 6'd1;
    month_inc = {1'b0, time_i.month} + 5'd1;

    sec_wrap   = sec_inc >= 7'(SecPerMin);
    min_wrap   = min_inc >= 7'(MinPerHour);
    hour_wrap  = hour_inc >= 6'(HourPerDay);
    month_wrap = month_inc >= 5'(MonthRoll);

    // The leap rule is year mod 4 alone, with no century exception.
    leap_feb = (time_i.year[1:0] == 2'b00) && (time_i.month == MonthFeb);
    if (leap_feb) begin
      day_roll = day_inc >= 6'(LeapFebRoll);
    end else begin
      day_roll = day_inc > {1'b0, days_in(time_i.month)};
    end

    // Each unit carries only when every smaller unit wrapped.
    c1 = sec_wrap;
    c2 = c1 && min_wrap;
    c3 = c2 && hour_wrap;
    c4 = c3 && day_roll;
    c5 = c4 && month_wrap;

    tick_time.second = sec_wrap ? '0 : sec_inc[5:0];
    tick_time.minute = c1 ? (min_wrap ? '0 : min_inc[5:0]) : time_i.minute;
    tick_time.hour   = c2 ? (hour_wrap ? '0 : hour_inc[4:0]) : time_i.hour;
    tick_time.day    = c3 ? (day_roll ? FirstDay : day_inc[4:0]) : time_i.day;
    tick_time.month  = c4 ? (month_wrap ? FirstMonth : month_inc[3:0]) : time_i.month;
    tick_time.year   = c5 ? time_i.year + 16'd1 : time_i.year;

    if (item_i.op == OpLoad) begin
      time_o.second = item_i.set_second;
      time_o.minute = item_i.set_minute;
      time_o.hour   = item_i.set_hour;
      time_o.day    = item_i.set_day;
      time_o.month  = item_i.set_month;
      time_o.year   = item_i.set_year;
      mask_o        = '0;
    end else begin
      time_o = tick_time;
      mask_o = {c5, c4, c3, c2, c1, 1'b1};
    end
  end

endmodule

/* dv/calendar_clock_tick_tb.sv */
`timescale 1ns / 100ps

module calendar_clock_tick_tb;
  import rtc_pkg::*;

  // Bits of the elapsed mask, one per calendar unit.
  localparam int unsigned SecondBit = 0;
  localparam int unsigned MinuteBit = 1;
  localparam int unsigned HourBit   = 2;
  localparam int unsigned DayBit    = 3;
  localparam int unsigned MonthBit  = 4;
  localparam int unsigned YearBit   = 5;

  // Rough number of input transactions to generate, directed part included.
  localparam int unsigned TargetItems = 1950;
  // Hard stop for the whole run, far above the slowest legal run.
  localparam int unsigned CycleLimit  = 200000;
  // Extra wait once every expected result has been taken.
  localparam int unsigned DrainCycles = 6;
  // Length of the long receiver hold-off and when it starts.
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned HoldAtItem  = 300;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  rtc_in_t  in_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rtc_out_t out_o;

  calendar_clock_tick u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // Items waiting to be offered, and the times the block must report, oldest first.
  rtc_in_t  pending_items[$];
  rtc_out_t expected_times[$];

  int unsigned total_items  = 0;
  int unsigned in_count     = 0;
  int unsigned out_count    = 0;
  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  // Our own copy of the calendar state, kept wider than the counters so that
  // out-of-range loads carry exactly as the block must handle them.
  int unsigned cal_second = ResetSecond;
  int unsigned cal_minute = ResetMinute;
  int unsigned cal_hour   = ResetHour;
  int unsigned cal_day    = ResetDay;
  int unsigned cal_month  = ResetMonth;
  int unsigned cal_year   = ResetYear;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Month lengths outside leap February. Codes that name no month get 31 days.
  function automatic int unsigned month_length(int unsigned month);
    if (month == 2) begin
      return 28;
    end else if (month == 4 || month == 6 || month == 9 || month == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // Applies one accepted item to the calendar copy and returns the result the
  // block has to produce for it. A tick carries unit by unit; each unit that
  // moves, wraparound included, sets its bit in the mask.
  function automatic rtc_out_t advance_calendar(rtc_in_t item);
    rtc_out_t    res;
    logic [5:0]  mask;
    int unsigned day_limit;
    mask = '0;
    if (item.op == OpLoad) begin
      cal_second = item.set_second;
      cal_minute = item.set_minute;
      cal_hour   = item.set_hour;
      cal_day    = item.set_day;
      cal_month  = item.set_month;
      cal_year   = item.set_year;
    end else begin
      mask[SecondBit] = 1'b1;
      cal_second++;
      if (cal_second >= SecPerMin) begin
        cal_second = 0;
        mask[MinuteBit] = 1'b1;
        cal_minute++;
        if (cal_minute >= MinPerHour) begin
          cal_minute = 0;
          mask[HourBit] = 1'b1;
          cal_hour++;
          if (cal_hour >= HourPerDay) begin
            cal_hour = 0;
            mask[DayBit] = 1'b1;
            cal_day++;
            // Leap February rolls once the day passes 29; the plain divide-by-four
            // rule applies, centuries included.
            if ((cal_year % 4) == 0 && cal_month == MonthFeb) begin
              day_limit = LeapFebRoll;
            end else begin
              day_limit = month_length(cal_month) + 1;
            end
            if (cal_day >= day_limit) begin
              cal_day = FirstDay;
              mask[MonthBit] = 1'b1;
              cal_month++;
              if (cal_month >= MonthRoll) begin
                cal_month = FirstMonth;
                mask[YearBit] = 1'b1;
                cal_year = (cal_year + 1) & 16'hFFFF;
              end
            end
          end
        end
      end
    end
    res.cur_second   = cal_second[5:0];
    res.cur_minute   = cal_minute[5:0];
    res.cur_hour     = cal_hour[4:0];
    res.cur_day      = cal_day[4:0];
    res.cur_month    = cal_month[3:0];
    res.cur_year     = cal_year[15:0];
    res.elapsed_mask = mask;
    return res;
  endfunction

  function automatic rtc_in_t load_item(int unsigned s, int unsigned m, int unsigned h,
                                        int unsigned d, int unsigned mo, int unsigned y);
    rtc_in_t item;
    item.op         = OpLoad;
    item.set_second = s[5:0];
    item.set_minute = m[5:0];
    item.set_hour   = h[4:0];
    item.set_day    = d[4:0];
    item.set_month  = mo[3:0];
    item.set_year   = y[15:0];
    return item;
  endfunction

  // A tick carries random set fields, which the block has to ignore.
  function automatic rtc_in_t tick_item();
    rtc_in_t item;
    item = rtc_in_t'($urandom);
    item.set_year = 16'($urandom);
    item.op = OpTick;
    return item;
  endfunction

  // Three idling phases by progress through the stimulus: the sender idles
  // lightly while the receiver stalls heavily, then the reverse, then neither.
  function automatic int unsigned sender_idle_pct();
    if (in_count < total_items / 3) begin
      return 16;
    end else if (in_count < (2 * total_items) / 3) begin
      return 55;
    end
    return 0;
  endfunction

  function automatic int unsigned receiver_stall_pct();
    if (in_count < total_items / 3) begin
      return 55;
    end else if (in_count < (2 * total_items) / 3) begin
      return 16;
    end
    return 0;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_error($sformatf("result %0d: %s is %0d, expected %0d", out_count, name, got,
                             want));
    end
  endtask

  // Driver. A new item goes out only when the bus is empty or the current
  // transaction completes at this edge, so valid and payload hold while stalled.
  // Each accepted transaction is run through the calendar copy right here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_times.push_back(advance_calendar(in_i));
        in_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_i       <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. Stalls at random per phase, and once holds ready low for a long
  // stretch while the sender keeps offering, so the pipeline fills and the
  // block has to push back on its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (!hold_done && in_count >= HoldAtItem) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct());
      end
    end
  end

  // Monitor. Every completed output transaction is matched against the oldest
  // expected time, field by field.
  always @(posedge clk_i) begin : monitor
    rtc_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_times.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", out_count));
      end else begin
        want = expected_times.pop_front();
        check_field("cur_second", out_o.cur_second, want.cur_second);
        check_field("cur_minute", out_o.cur_minute, want.cur_minute);
        check_field("cur_hour", out_o.cur_hour, want.cur_hour);
        check_field("cur_day", out_o.cur_day, want.cur_day);
        check_field("cur_month", out_o.cur_month, want.cur_month);
        check_field("cur_year", out_o.cur_year, want.cur_year);
        check_field("elapsed_mask", out_o.elapsed_mask, want.elapsed_mask);
      end
      out_count++;
    end
  end

  // Watchdog for a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("calendar_clock_tick_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned ticks;
    int unsigned s, m, h, d, mo, y;

    // Directed part. A first tick straight out of reset.
    pending_items.push_back(tick_item());
    // All-zero load, including day and month zero, then a tick.
    pending_items.push_back(load_item(0, 0, 0, 0, 0, 0));
    pending_items.push_back(tick_item());
    // Last second of the last year: every unit rolls and the year wraps to zero.
    pending_items.push_back(load_item(59, 59, 23, 31, 12, 65535));
    pending_items.push_back(tick_item());
    // Every set field at its all-ones value: seconds, minutes and hours beyond
    // range roll at once, month fifteen counts 31 days and rolls into a new year.
    pending_items.push_back(load_item(63, 63, 31, 31, 15, 65535));
    pending_items.push_back(tick_item());
    // Leap February: the 28th moves to the 29th, the 29th moves to March 1st.
    pending_items.push_back(load_item(59, 59, 23, 28, 2, 2024));
    pending_items.push_back(tick_item());
    pending_items.push_back(load_item(59, 59, 23, 29, 2, 2024));
    pending_items.push_back(tick_item());
    // Ordinary February ends on the 28th.
    pending_items.push_back(load_item(59, 59, 23, 28, 2, 2023));
    pending_items.push_back(tick_item());
    // Century years still count as leap years here.
    pending_items.push_back(load_item(59, 59, 23, 28, 2, 2100));
    pending_items.push_back(tick_item());
    // A thirty-day month.
    pending_items.push_back(load_item(59, 59, 23, 30, 4, 1999));
    pending_items.push_back(tick_item());
    // Month zero counts 31 days and advances to January.
    pending_items.push_back(load_item(59, 59, 23, 31, 0, 7));
    pending_items.push_back(tick_item());
    // Month thirteen rolls straight into the next year.
    pending_items.push_back(load_item(59, 59, 23, 31, 13, 40000));
    pending_items.push_back(tick_item());
    // Hours beyond range roll to zero; a day past the month length rolls too.
    pending_items.push_back(load_item(59, 59, 30, 31, 6, 12));
    pending_items.push_back(tick_item());
    // Plain ticks inside a minute.
    pending_items.push_back(tick_item());
    pending_items.push_back(tick_item());

    // Random part: mostly loads close to a rollover followed by a run of ticks,
    // so that carries reach days, months and years often. Some bare tick runs
    // and some fully random loads fill in the rest.
    while (pending_items.size() < TargetItems) begin
      kind  = $urandom_range(0, 9);
      ticks = 0;
      if (kind < 7) begin
        s  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 63) : $urandom_range(50, 59);
        m  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63) : 59;
        h  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : 23;
        d  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(27, 31);
        mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        case ($urandom_range(0, 7))
          0:       y = 65535;
          1, 2, 3: y = $urandom & 32'hFFFC;
          default: y = $urandom & 32'hFFFF;
        endcase
        pending_items.push_back(load_item(s, m, h, d, mo, y));
        ticks = $urandom_range(1, 12);
      end else if (kind < 9) begin
        ticks = $urandom_range(1, 20);
      end else begin
        pending_items.push_back(load_item($urandom, $urandom, $urandom, $urandom, $urandom,
                                          $urandom));
        ticks = $urandom_range(0, 4);
      end
      repeat (ticks) pending_items.push_back(tick_item());
    end
    total_items = pending_items.size();

    // Single reset at the start of the run.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Let everything go through, then wait for the last results to drain.
    while (in_count < total_items) @(posedge clk_i);
    while (expected_times.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("calendar_clock_tick_tb passed");
    end else begin
      $display("calendar_clock_tick_tb failed");
    end
    $finish;
  end

endmodule
